// File: rtl/sorted_symbol_range_lookup_core_defines.svh
// ----------------------------------------------------------------------------
// Sorted symbol range lookup: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_SYMBOL_RANGE_LOOKUP_CORE_DEFINES_SVH
`define SORTED_SYMBOL_RANGE_LOOKUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SSRL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ssrl assertion failed");
`define SSRL_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ssrl assertion failed");
`else
`define SSRL_ASSERT(label, clk, rst, prop)
`define SSRL_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: rtl/ssrl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted symbol range lookup package
// Transfer types, action and status codes shared by the core and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssrl_pkg;

   localparam int ADDR_W = 64;
   localparam int SIZE_W = 31;
   localparam int SYM_W  = 16;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_CLEAR  = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] address;
      logic [SYM_W-1:0]  symbol_id;
      logic [SIZE_W-1:0] entry_size;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SYM_W-1:0]  found_id;
      logic [ADDR_W-1:0] offset;
   } rsp_type;

   typedef struct packed {
      logic              insert_en;
      logic              lookup_en;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] entry_size;
   } cell_ctrl_type;

   typedef struct packed {
      logic              hit;
      logic              last;
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } cell_sel_type;

endpackage

`default_nettype wire

// File: rtl/sorted_symbol_range_lookup_core.sv
// One item at a time: the request is registered, the cell row acts in ST_EXEC,
// the match is gathered through a two-level registered OR tree (ST_GATHER, then
// ST_MERGE), then one 64-bit subtract and compare form the result, which is
// registered in ST_FINISH. The result strobe cannot be stalled.
// Reset clears the entry count and the control state; cell contents are kept.
// ----------------------------------------------------------------------------
// Sorted symbol range lookup core
// Sorted interval table held in a row of shifting cells, with insert,
// clear and address lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_symbol_range_lookup_core_defines.svh"

module sorted_symbol_range_lookup_core import ssrl_pkg::*; #(
   parameter int TABLE_ENTRIES = 256,
   parameter int ID_WIDTH      = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int GROUP  = 16;
   localparam int GROUPS = (TABLE_ENTRIES + GROUP - 1) / GROUP;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GATHER,
      ST_MERGE,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   req_type             req_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                full_ff;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff, rsp_in;

   cell_ctrl_type       ctrl;
   logic [ID_WIDTH-1:0] new_id;
   logic                full;

   logic [TABLE_ENTRIES-1:0] le;
   logic [TABLE_ENTRIES-1:0] occ;
   logic [ADDR_W-1:0]        c_start [TABLE_ENTRIES];
   logic [SIZE_W-1:0]        c_size  [TABLE_ENTRIES];
   logic [ID_WIDTH-1:0]      c_id    [TABLE_ENTRIES];
   cell_sel_type             c_sel   [TABLE_ENTRIES];
   logic [ID_WIDTH-1:0]      c_sel_id[TABLE_ENTRIES];

   cell_sel_type        grp_sel_ff [GROUPS];
   cell_sel_type        grp_sel_in [GROUPS];
   logic [ID_WIDTH-1:0] grp_id_ff  [GROUPS];
   logic [ID_WIDTH-1:0] grp_id_in  [GROUPS];
   cell_sel_type        top_sel_ff, top_sel_in;
   logic [ID_WIDTH-1:0] top_id_ff, top_id_in;

   logic [ADDR_W-1:0]   diff;
   logic                hit;

   assign full   = (count_ff == CNT_W'(TABLE_ENTRIES));
   assign new_id = ID_WIDTH'(req_ff.symbol_id);

   always_comb begin
      ctrl.insert_en  = (state_ff == ST_EXEC) && (req_ff.action == ACT_INSERT) && !full;
      ctrl.lookup_en  = (state_ff == ST_EXEC) && (req_ff.action == ACT_LOOKUP);
      ctrl.address    = req_ff.address;
      ctrl.entry_size = req_ff.entry_size;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      logic                l_le;
      logic [ADDR_W-1:0]   l_start;
      logic [SIZE_W-1:0]   l_size;
      logic [ID_WIDTH-1:0] l_id;
      logic                r_le;
      logic                r_occ;

      assign occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign l_le    = 1'b1;
         assign l_start = '0;
         assign l_size  = '0;
         assign l_id    = '0;
      end else begin : g_body
         assign l_le    = le[i-1];
         assign l_start = c_start[i-1];
         assign l_size  = c_size[i-1];
         assign l_id    = c_id[i-1];
      end

      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign r_le  = 1'b0;
         assign r_occ = 1'b0;
      end else begin : g_next
         assign r_le  = le[i+1];
         assign r_occ = occ[i+1];
      end

      ssrl_cell #(
         .ID_WIDTH(ID_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_id    (new_id),
         .occupied  (occ[i]),
         .left_le   (l_le),
         .left_start(l_start),
         .left_size (l_size),
         .left_id   (l_id),
         .right_le  (r_le),
         .right_occ (r_occ),
         .le        (le[i]),
         .start     (c_start[i]),
         .size      (c_size[i]),
         .id        (c_id[i]),
         .sel       (c_sel[i]),
         .sel_id    (c_sel_id[i])
      );
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_sel_in[g] = '0;
         grp_id_in[g]  = '0;
         for (int k = 0; k < GROUP; k++) begin
            if (g * GROUP + k < TABLE_ENTRIES) begin
               grp_sel_in[g] = grp_sel_in[g] | c_sel[g * GROUP + k];
               grp_id_in[g]  = grp_id_in[g] | c_sel_id[g * GROUP + k];
            end
         end
      end
   end

   always_comb begin
      top_sel_in = '0;
      top_id_in  = '0;
      for (int g = 0; g < GROUPS; g++) begin
         top_sel_in = top_sel_in | grp_sel_ff[g];
         top_id_in  = top_id_in | grp_id_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_GATHER) begin
         grp_sel_ff <= grp_sel_in;
         grp_id_ff  <= grp_id_in;
      end
      if (state_ff == ST_MERGE) begin
         top_sel_ff <= top_sel_in;
         top_id_ff  <= top_id_in;
      end
   end

   assign diff = req_ff.address - top_sel_ff.start;
   assign hit  = top_sel_ff.hit &&
                 (!top_sel_ff.last || (diff < {{(ADDR_W - SIZE_W){1'b0}}, top_sel_ff.size}));

   always_comb begin
      rsp_in = '0;
      case (req_ff.action)
         ACT_INSERT: begin
            if (full_ff) begin
               rsp_in.status = STATUS_FULL;
            end
         end
         ACT_LOOKUP: begin
            if (hit) begin
               rsp_in.status   = STATUS_OK;
               rsp_in.found_id = SYM_W'(top_id_ff);
               rsp_in.offset   = diff;
            end else begin
               rsp_in.status = STATUS_MISS;
            end
         end
         default: begin
            rsp_in.status = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         full_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               full_ff <= full;
               if (ctrl.insert_en) begin
                  count_ff <= count_ff + 1'b1;
               end else if (req_ff.action == ACT_CLEAR) begin
                  count_ff <= '0;
               end
               state_ff <= ST_GATHER;
            end
            ST_GATHER: begin
               state_ff <= ST_MERGE;
            end
            ST_MERGE: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               rsp_ff        <= rsp_in;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `SSRL_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(TABLE_ENTRIES))
   `SSRL_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `SSRL_ASSERT(a_strobe_after_finish, clock, reset, rsp_strobe |-> !busy)
   `SSRL_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_strobe))

endmodule

`default_nettype wire

// File: rtl/ssrl_cell.sv
// ----------------------------------------------------------------------------
// Sorted symbol range lookup cell
// One table slot: holds an entry, shifts right on insert, flags a lookup match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssrl_cell import ssrl_pkg::*; #(
   parameter int ID_WIDTH = 16
) (
   input  wire logic                clock,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [ID_WIDTH-1:0] new_id,
   input  wire logic                occupied,
   input  wire logic                left_le,
   input  wire logic [ADDR_W-1:0]   left_start,
   input  wire logic [SIZE_W-1:0]   left_size,
   input  wire logic [ID_WIDTH-1:0] left_id,
   input  wire logic                right_le,
   input  wire logic                right_occ,
   output logic                     le,
   output logic [ADDR_W-1:0]        start,
   output logic [SIZE_W-1:0]        size,
   output logic [ID_WIDTH-1:0]      id,
   output cell_sel_type             sel,
   output logic [ID_WIDTH-1:0]      sel_id
);

   logic [ADDR_W-1:0]   start_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [ID_WIDTH-1:0] id_ff;
   cell_sel_type        sel_ff, sel_in;
   logic [ID_WIDTH-1:0] sel_id_ff, sel_id_in;
   logic                match;

   assign le    = occupied && (start_ff <= ctrl.address);
   assign match = le && !right_le;

   always_comb begin
      sel_in.hit   = match;
      sel_in.last  = match && !right_occ;
      sel_in.start = match ? start_ff : '0;
      sel_in.size  = match ? size_ff : '0;
      sel_id_in    = match ? id_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert_en && !le) begin
         if (left_le) begin
            start_ff <= ctrl.address;
            size_ff  <= ctrl.entry_size;
            id_ff    <= new_id;
         end else begin
            start_ff <= left_start;
            size_ff  <= left_size;
            id_ff    <= left_id;
         end
      end
      if (ctrl.lookup_en) begin
         sel_ff    <= sel_in;
         sel_id_ff <= sel_id_in;
      end
   end

   assign start  = start_ff;
   assign size   = size_ff;
   assign id     = id_ff;
   assign sel    = sel_ff;
   assign sel_id = sel_id_ff;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Sorted symbol range lookup core testbench
// Drives insert, clear, lookup and unused-code commands through start/busy
// handshake, predicts every answer from a private copy of the sorted symbol
// table and compares each strobed answer field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import ssrl_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int SYMBOL_BITS = 16;
   localparam int RANDOM_ITEMS = 1450;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   class symbol_table_tracker;
      logic [ADDR_W-1:0] start_tab[TABLE_DEPTH];
      logic [SIZE_W-1:0] size_tab[TABLE_DEPTH];
      logic [SYM_W-1:0]  id_tab[TABLE_DEPTH];
      int unsigned       fill;
      rsp_type           expected_answers[$];
      int unsigned       fail_count;

      function new();
         fill = 0;
         fail_count = 0;
      endfunction

      function int unsigned entries_not_above(logic [ADDR_W-1:0] addr);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = fill;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (start_tab[mid] <= addr) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         return lo;
      endfunction

      function void note_request(req_type r);
         rsp_type           answer;
         int unsigned       pos;
         int unsigned       idx;
         logic [ADDR_W-1:0] delta;
         logic              hit;
         answer = '0;
         answer.status = STATUS_OK;
         case (r.action)
            ACT_INSERT: begin
               if (fill >= TABLE_DEPTH) begin
                  answer.status = STATUS_FULL;
               end else begin
                  pos = entries_not_above(r.address);
                  for (int i = int'(fill); i > int'(pos); i--) begin
                     start_tab[i] = start_tab[i-1];
                     size_tab[i]  = size_tab[i-1];
                     id_tab[i]    = id_tab[i-1];
                  end
                  start_tab[pos] = r.address;
                  size_tab[pos]  = r.entry_size;
                  id_tab[pos]    = r.symbol_id;
                  fill++;
               end
            end
            ACT_CLEAR: begin
               fill = 0;
            end
            ACT_LOOKUP: begin
               pos = entries_not_above(r.address);
               answer.status = STATUS_MISS;
               if (pos > 0) begin
                  idx = pos - 1;
                  delta = r.address - start_tab[idx];
                  if (idx + 1 < fill) begin
                     hit = r.address < start_tab[idx+1];
                  end else begin
                     hit = delta < {{(ADDR_W-SIZE_W){1'b0}}, size_tab[idx]};
                  end
                  if (hit) begin
                     answer.status   = STATUS_OK;
                     answer.found_id = id_tab[idx];
                     answer.offset   = delta;
                  end
               end
            end
            default: begin
            end
         endcase
         expected_answers.push_back(answer);
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (expected_answers.size() == 0) begin
            $error("unexpected answer: status %0d found_id %0h offset %0h",
                   got.status, got.found_id, got.offset);
            fail_count++;
            return;
         end
         want = expected_answers.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
         end
         if (got.found_id !== want.found_id) begin
            $error("found_id: expected %0h, actual %0h", want.found_id, got.found_id);
            fail_count++;
         end
         if (got.offset !== want.offset) begin
            $error("offset: expected %0h, actual %0h", want.offset, got.offset);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_answers.size();
      endfunction
   endclass

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   symbol_table_tracker tracker = new();
   bit          idle_enabled = 1'b1;
   int unsigned item_count = 0;

   sorted_symbol_range_lookup_core #(
      .TABLE_ENTRIES(TABLE_DEPTH),
      .ID_WIDTH     (SYMBOL_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         tracker.check_answer(rsp_item);
      end
   end

   function automatic req_type make_req(logic [1:0] action, logic [ADDR_W-1:0] addr,
                                        logic [SYM_W-1:0] sym, logic [SIZE_W-1:0] sz);
      req_type r;
      r.action     = action;
      r.address    = addr;
      r.symbol_id  = sym;
      r.entry_size = sz;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] random_address();
      return {$urandom(), $urandom()};
   endfunction

   task automatic transfer_item(input req_type item);
      if (idle_enabled && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      tracker.note_request(item);
      if (item.action != ACT_UNUSED) begin
         item_count++;
      end
   endtask

   task automatic drain_answers();
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic send_insert(input logic [ADDR_W-1:0] base);
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] sz;
      int unsigned       pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         addr = random_address();
      end else if (pick <= 2 && tracker.fill > 0) begin
         addr = tracker.start_tab[$urandom_range(0, tracker.fill - 1)];
      end else begin
         addr = base + $urandom_range(0, 65535);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         sz = '0;
      end else if (pick == 1) begin
         sz = SIZE_W'($urandom());
      end else if (pick == 2) begin
         sz = '1;
      end else begin
         sz = SIZE_W'($urandom_range(1, 4096));
      end
      transfer_item(make_req(ACT_INSERT, addr, SYM_W'($urandom()), sz));
   endtask

   task automatic send_lookup();
      logic [ADDR_W-1:0] addr;
      int unsigned       idx;
      int unsigned       pick;
      pick = $urandom_range(0, 9);
      if (tracker.fill == 0 || pick == 0) begin
         addr = random_address();
      end else begin
         idx = $urandom_range(0, tracker.fill - 1);
         if (pick <= 5) begin
            addr = tracker.start_tab[idx] + $urandom_range(0, tracker.size_tab[idx]);
         end else if (pick <= 7) begin
            addr = tracker.start_tab[idx] - 1;
         end else begin
            addr = tracker.start_tab[idx] + tracker.size_tab[idx] - $urandom_range(0, 1);
         end
      end
      transfer_item(make_req(ACT_LOOKUP, addr, SYM_W'($urandom()), SIZE_W'($urandom())));
   endtask

   task automatic send_plain(input logic [1:0] action);
      transfer_item(make_req(action, random_address(), SYM_W'($urandom()),
                             SIZE_W'($urandom())));
   endtask

   initial begin
      logic [ADDR_W-1:0] base;
      int unsigned       phase;
      int unsigned       pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      transfer_item(make_req(ACT_LOOKUP, 64'h0, 16'h0, 31'h0));
      send_plain(ACT_UNUSED);
      transfer_item(make_req(ACT_INSERT, 64'h1000, 16'hFFFF, 31'h0));
      transfer_item(make_req(ACT_LOOKUP, 64'h1000, 16'h0, 31'h0));
      transfer_item(make_req(ACT_INSERT, 64'h1000, 16'h0001, 31'h10));
      transfer_item(make_req(ACT_LOOKUP, 64'h1000, 16'h0, 31'h0));
      transfer_item(make_req(ACT_LOOKUP, 64'h0FFF, 16'h0, 31'h0));
      transfer_item(make_req(ACT_LOOKUP, 64'h100F, 16'h0, 31'h0));
      transfer_item(make_req(ACT_LOOKUP, 64'h1010, 16'h0, 31'h0));
      transfer_item(make_req(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 16'h0, 31'h7FFF_FFFF));
      transfer_item(make_req(ACT_LOOKUP, 64'h2000, 16'h0, 31'h0));
      transfer_item(make_req(ACT_LOOKUP, '1, 16'h0, 31'h0));
      transfer_item(make_req(ACT_INSERT, 64'h0, 16'hAAAA, 31'h1));
      transfer_item(make_req(ACT_LOOKUP, 64'h0, '1, '1));
      transfer_item(make_req(ACT_INSERT, '1, 16'h5555, 31'h7FFF_FFFF));
      transfer_item(make_req(ACT_LOOKUP, '1, 16'h0, 31'h0));
      send_plain(ACT_CLEAR);
      transfer_item(make_req(ACT_LOOKUP, 64'h1000, 16'h0, 31'h0));
      send_plain(ACT_UNUSED);
      transfer_item(make_req(ACT_INSERT, 64'h8000_0000_0000_0000, 16'h1234, 31'h7FFF_FFFF));
      transfer_item(make_req(ACT_LOOKUP, 64'h8000_0000_7FFF_FFFE, 16'h0, 31'h0));
      transfer_item(make_req(ACT_LOOKUP, 64'h8000_0000_7FFF_FFFF, 16'h0, 31'h0));
      send_plain(ACT_CLEAR);
      drain_answers();

      item_count = 0;
      phase = 0;
      while (item_count < RANDOM_ITEMS) begin
         phase++;
         idle_enabled = !(phase >= 4 && phase <= 8);
         pick = $urandom_range(0, 5);
         base = (pick == 0) ? 64'hFFFF_FFFF_FFFF_0000 : (pick == 1) ? 64'h0 : random_address();
         if (phase == 3) begin
            send_plain(ACT_CLEAR);
            repeat (TABLE_DEPTH + 6) begin
               send_insert(base);
               if ($urandom_range(0, 3) == 0) begin
                  send_lookup();
               end
            end
            repeat (20) send_lookup();
         end else begin
            if ($urandom_range(0, 4) != 0) begin
               send_plain(ACT_CLEAR);
            end
            repeat ($urandom_range(1, 24)) send_insert(base);
            repeat ($urandom_range(8, 40)) begin
               pick = $urandom_range(0, 99);
               if (pick < 80) begin
                  send_lookup();
               end else if (pick < 90) begin
                  send_insert(base);
               end else if (pick < 95) begin
                  send_plain(ACT_UNUSED);
               end else if (pick < 97) begin
                  send_plain(ACT_CLEAR);
               end else begin
                  send_plain(ACT_LOOKUP);
               end
            end
         end
         if (phase == 1 || $urandom_range(0, 3) == 0) begin
            drain_answers();
         end
      end

      drain_answers();
      repeat (10) @(posedge clock);
      if (tracker.fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
